// File: design/pcl_pkg.sv
package pcl_pkg;

    localparam int CAPACITY = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 6;
    localparam int CHAR_W   = 8;
    localparam int CMP_W    = POS_W + 1;

    typedef enum logic [1:0] {
        F_INSERT = 2'd0,
        F_DELETE = 2'd1,
        F_GET    = 2'd2,
        F_PRINT  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_CHAR    = 2'd0,
        ST_INVALID = 2'd1,
        ST_END     = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_PUT,
        S_DEL,
        S_GET,
        S_PRINT,
        S_RESP
    } t_state;

    typedef struct packed {
        logic              valid;
        t_status           status;
        logic [CHAR_W-1:0] char_out;
        logic              last;
    } t_emit;

endpackage

// File: design/pcl_ram.sv
module pcl_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/pcl_ctrl.sv
module pcl_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  pcl_pkg::t_func             i_func,
    input  logic [pcl_pkg::POS_W-1:0]  i_position,
    input  logic [pcl_pkg::CHAR_W-1:0] i_elem,
    input  logic                       i_out_free,
    output pcl_pkg::t_emit             o_emit,
    output logic                       o_we,
    output logic [pcl_pkg::ADDR_W-1:0] o_waddr,
    output logic [pcl_pkg::CHAR_W-1:0] o_wdata,
    output logic                       o_re,
    output logic [pcl_pkg::ADDR_W-1:0] o_raddr,
    input  logic [pcl_pkg::CHAR_W-1:0] i_rdata
);

    import pcl_pkg::*;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [ADDR_W-1:0]   r_src, n_src;
    logic [ADDR_W-1:0]   r_pos, n_pos;
    logic [CHAR_W-1:0]   r_elem, n_elem;
    t_status             r_rst, n_rst;

    logic                accept;
    logic [CMP_W-1:0]    pos_x;
    logic [CMP_W-1:0]    cnt_x;
    logic                pos_nz;
    logic                ins_ok;
    logic                rd_ok;
    logic                full;
    logic [POS_W-1:0]    pos_m1;
    logic [ADDR_W-1:0]   pos_idx;
    logic [ADDR_W-1:0]   cnt_m1;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    assign pos_x   = {1'b0, i_position};
    assign cnt_x   = CMP_W'(r_count);
    assign pos_nz  = (i_position != '0);
    assign ins_ok  = pos_nz && (pos_x <= cnt_x + CMP_W'(1));
    assign rd_ok   = pos_nz && (pos_x <= cnt_x);
    assign full    = (r_count == CNT_W'(CAPACITY));
    assign pos_m1  = i_position - POS_W'(1);
    assign pos_idx = ADDR_W'(pos_m1);
    assign cnt_m1  = ADDR_W'(r_count - CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src  <= n_src;
        r_pos  <= n_pos;
        r_elem <= n_elem;
        r_rst  <= n_rst;
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_src   = r_src;
        n_pos   = r_pos;
        n_elem  = r_elem;
        n_rst   = r_rst;
        o_we    = 1'b0;
        o_waddr = '0;
        o_wdata = '0;
        o_re    = 1'b0;
        o_raddr = '0;
        o_emit  = '{valid: 1'b0, status: ST_CHAR, char_out: '0, last: 1'b0};

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pos  = pos_idx;
                    n_elem = i_elem;
                    unique case (i_func)
                        F_INSERT: begin
                            if (!ins_ok) begin
                                n_rst   = ST_INVALID;
                                n_state = S_RESP;
                            end else if (full) begin
                                n_rst   = ST_FULL;
                                n_state = S_RESP;
                            end else if (pos_x == cnt_x + CMP_W'(1)) begin
                                // append at the tail
                                o_we    = 1'b1;
                                o_waddr = pos_idx;
                                o_wdata = i_elem;
                                n_count = r_count + CNT_W'(1);
                            end else begin
                                o_re    = 1'b1;
                                o_raddr = cnt_m1;
                                n_src   = cnt_m1;
                                n_state = S_INS;
                            end
                        end
                        F_DELETE: begin
                            if (!rd_ok) begin
                                n_rst   = ST_INVALID;
                                n_state = S_RESP;
                            end else if (pos_x == cnt_x) begin
                                n_count = r_count - CNT_W'(1);
                            end else begin
                                o_re    = 1'b1;
                                o_raddr = ADDR_W'(i_position);
                                n_src   = ADDR_W'(i_position);
                                n_state = S_DEL;
                            end
                        end
                        F_GET: begin
                            if (!rd_ok) begin
                                n_rst   = ST_INVALID;
                                n_state = S_RESP;
                            end else begin
                                o_re    = 1'b1;
                                o_raddr = pos_idx;
                                n_state = S_GET;
                            end
                        end
                        F_PRINT: begin
                            if (r_count == '0) begin
                                n_rst   = ST_END;
                                n_state = S_RESP;
                            end else begin
                                o_re    = 1'b1;
                                o_raddr = '0;
                                n_src   = '0;
                                n_state = S_PRINT;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_INS: begin
                // move one cell back while the next source is read
                o_we    = 1'b1;
                o_waddr = r_src + ADDR_W'(1);
                o_wdata = i_rdata;
                if (r_src == r_pos) begin
                    n_state = S_PUT;
                end else begin
                    o_re    = 1'b1;
                    o_raddr = r_src - ADDR_W'(1);
                    n_src   = r_src - ADDR_W'(1);
                end
            end
            S_PUT: begin
                o_we    = 1'b1;
                o_waddr = r_pos;
                o_wdata = r_elem;
                n_count = r_count + CNT_W'(1);
                n_state = S_IDLE;
            end
            S_DEL: begin
                o_we    = 1'b1;
                o_waddr = r_src - ADDR_W'(1);
                o_wdata = i_rdata;
                if (r_src == cnt_m1) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_IDLE;
                end else begin
                    o_re    = 1'b1;
                    o_raddr = r_src + ADDR_W'(1);
                    n_src   = r_src + ADDR_W'(1);
                end
            end
            S_GET: begin
                o_emit = '{valid: 1'b1, status: ST_CHAR, char_out: i_rdata, last: 1'b1};
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_PRINT: begin
                o_emit = '{valid: 1'b1, status: ST_CHAR, char_out: i_rdata, last: 1'b0};
                if (i_out_free) begin
                    if (r_src == cnt_m1) begin
                        n_rst   = ST_END;
                        n_state = S_RESP;
                    end else begin
                        o_re    = 1'b1;
                        o_raddr = r_src + ADDR_W'(1);
                        n_src   = r_src + ADDR_W'(1);
                    end
                end
            end
            S_RESP: begin
                o_emit = '{valid: 1'b1, status: r_rst, char_out: '0, last: 1'b1};
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_no_same_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_we && o_re) |-> (o_waddr != o_raddr))
        else $error("read and write hit the same entry");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !accept) |=> (r_state == S_IDLE))
        else $error("left idle without a beat");

    a_ins_above_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> (o_waddr > r_pos))
        else $error("shift wrote below the insert position");

    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit.valid && !i_out_free && r_state == S_GET) |=> (r_state == S_GET && $stable(i_rdata)))
        else $error("get result lost while stalled");

endmodule

// File: design/positional_char_list.sv
// get and print read the single registered memory read port, then pass the output register
// insert shifts cells back, then writes, append writes at once; delete shifts cells forward
// and at the tail only lowers the count; print gives one char a cycle while the output is
// free, then the end marker; errors come from the response state; no beat is taken until the
// control is idle; reset clears the element count and control state; memory is not cleared
module positional_char_list (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // position[5:0], elem[13:6]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // char_out[7:0]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast
);

    import pcl_pkg::*;

    t_emit              emit;
    logic               out_free;
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [CHAR_W-1:0]  wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
    logic [CHAR_W-1:0]  rdata;

    logic               r_ov;
    t_status            r_ost;
    logic [CHAR_W-1:0]  r_och;
    logic               r_olast;

    assign out_free = !r_ov || m_axis_tready;

    pcl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_func     (t_func'(s_axis_tuser)),
        .i_position (s_axis_tdata[POS_W-1:0]),
        .i_elem     (s_axis_tdata[POS_W+CHAR_W-1:POS_W]),
        .i_out_free (out_free),
        .o_emit     (emit),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_re       (re),
        .o_raddr    (raddr),
        .i_rdata    (rdata)
    );

    pcl_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (CHAR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_free) begin
            r_ov <= emit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && emit.valid) begin
            r_ost   <= emit.status;
            r_och   <= emit.char_out;
            r_olast <= emit.last;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_och;
    assign m_axis_tuser  = r_ost;
    assign m_axis_tlast  = r_olast;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import pcl_pkg::*;

    localparam int LIMIT     = 600000;
    localparam int LONG_HOLD = 400;
    localparam int GROW      = 0;
    localparam int SHRINK    = 1;
    localparam int MIXED     = 2;

    typedef struct {
        t_func             fn;
        logic [POS_W-1:0]  pos;
        logic [CHAR_W-1:0] ch;
        bit                hold;
    } t_cmd;

    typedef struct {
        t_status           st;
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;    // position[5:0], elem[13:6]
    logic [1:0]  s_axis_tuser;    // func[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;    // char_out[7:0]
    logic [1:0]  m_axis_tuser;    // status[1:0]
    logic        m_axis_tlast;

    t_cmd              cmd_q[$];
    t_reply            reply_q[$];
    logic [CHAR_W-1:0] list_mem [CAPACITY];
    int                list_len   = 0;
    int                gen_len    = 0;
    int                n_taken    = 0;
    int                n_total    = 0;
    int                stall_at   = 0;
    int                cycles     = 0;
    int                bad_cnt    = 0;
    int                n_checked  = 0;
    int                full_hits  = 0;
    int                op_seen[4] = '{0, 0, 0, 0};
    int                send_gap   = 0;
    int                recv_gap   = 0;
    int                hold_cnt   = 0;
    bit                stall_done = 1'b0;
    logic              in_fire    = 1'b0;

    positional_char_list uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    task automatic apply_list_op(input t_func fn, input int pos, input logic [CHAR_W-1:0] ch);
        t_reply r;
        int     i;
        r.st   = ST_INVALID;
        r.ch   = '0;
        r.last = 1'b1;
        op_seen[fn]++;
        case (fn)
            F_INSERT: begin
                if (pos == 0 || pos > list_len + 1) begin
                    reply_q.push_back(r);
                end else if (list_len >= CAPACITY) begin
                    r.st = ST_FULL;
                    reply_q.push_back(r);
                    full_hits++;
                end else begin
                    for (i = list_len; i > pos - 1; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[pos-1] = ch;
                    list_len++;
                end
            end
            F_DELETE: begin
                if (pos == 0 || pos > list_len) begin
                    reply_q.push_back(r);
                end else begin
                    for (i = pos - 1; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            F_GET: begin
                if (pos != 0 && pos <= list_len) begin
                    r.st = ST_CHAR;
                    r.ch = list_mem[pos-1];
                end
                reply_q.push_back(r);
            end
            default: begin
                for (i = 0; i < list_len; i++) begin
                    r.st   = ST_CHAR;
                    r.ch   = list_mem[i];
                    r.last = 1'b0;
                    reply_q.push_back(r);
                end
                r.st   = ST_END;
                r.ch   = '0;
                r.last = 1'b1;
                reply_q.push_back(r);
            end
        endcase
    endtask

    task automatic push_cmd(input t_func fn, input int pos, input int ch, input int hold);
        t_cmd c;
        c.fn   = fn;
        c.pos  = pos[POS_W-1:0];
        c.ch   = ch[CHAR_W-1:0];
        c.hold = (hold != 0);
        cmd_q.push_back(c);
        if (fn == F_INSERT && pos >= 1 && pos <= gen_len + 1 && gen_len < CAPACITY)
            gen_len++;
        else if (fn == F_DELETE && pos >= 1 && pos <= gen_len)
            gen_len--;
    endtask

    task automatic rand_cmd(input int mode, input bit hold);
        int    r;
        int    hi;
        int    pos;
        int    lim_ins;
        int    lim_del;
        int    lim_get;
        t_func fn;
        case (mode)
            GROW: begin
                lim_ins = 70; lim_del = 80; lim_get = 93;
            end
            SHRINK: begin
                lim_ins = 15; lim_del = 70; lim_get = 92;
            end
            default: begin
                lim_ins = 35; lim_del = 60; lim_get = 88;
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < lim_ins)
            fn = F_INSERT;
        else if (r < lim_del)
            fn = F_DELETE;
        else if (r < lim_get)
            fn = F_GET;
        else
            fn = F_PRINT;
        hi = (fn == F_INSERT) ? gen_len + 1 : gen_len;
        if (hi >= 1 && $urandom_range(0, 99) < 85)
            pos = $urandom_range(1, hi);
        else
            pos = $urandom_range(0, 63);
        push_cmd(fn, pos, $urandom_range(0, 255), int'(hold));
    endtask

    // beat sender
    always @(negedge i_clk) begin : drive
        t_cmd c;
        bit   quiet;
        quiet = (n_taken >= n_total - 40);
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (cmd_q.size() == 0 || (cmd_q[0].hold && reply_q.size() != 0)) begin
                s_axis_tvalid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(0, 17);
                s_axis_tvalid <= 1'b0;
            end else begin
                c = cmd_q.pop_front();
                s_axis_tdata  <= {2'b00, c.ch, c.pos};
                s_axis_tuser  <= c.fn;
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin : sink
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (!stall_done && n_taken > stall_at) begin
            stall_done = 1'b1;
            hold_cnt   = LONG_HOLD - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_axis_tready <= 1'b0;
        end else if (n_taken < n_total - 40 && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 17);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check
        t_reply w;
        cycles++;
        if (cycles > LIMIT) begin
            $display("positional_char_list verification failed");
            $finish;
        end else begin
            in_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                n_checked++;
                if (reply_q.size() == 0) begin
                    bad_cnt++;
                    if (bad_cnt < 40)
                        $display({"%0t: unexpected beat, expected none, ",
                                  "actual status %0d char %02h last %b"},
                                 $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                end else begin
                    w = reply_q.pop_front();
                    if (m_axis_tuser !== w.st) begin
                        bad_cnt++;
                        if (bad_cnt < 40)
                            $display("%0t: status expected %0d actual %0d",
                                     $time, w.st, m_axis_tuser);
                    end
                    if (m_axis_tdata !== w.ch) begin
                        bad_cnt++;
                        if (bad_cnt < 40)
                            $display("%0t: char expected %02h actual %02h",
                                     $time, w.ch, m_axis_tdata);
                    end
                    if (m_axis_tlast !== w.last) begin
                        bad_cnt++;
                        if (bad_cnt < 40)
                            $display("%0t: last expected %b actual %b",
                                     $time, w.last, m_axis_tlast);
                    end
                end
            end
            if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
                apply_list_op(t_func'(s_axis_tuser), int'(s_axis_tdata[POS_W-1:0]),
                              s_axis_tdata[POS_W+CHAR_W-1:POS_W]);
                n_taken++;
            end
        end
    end

    initial begin : stim
        int n_rand;
        int phase;
        int mode;
        int k;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        for (k = 0; k < CAPACITY; k++)
            list_mem[k] = '0;

        // empty list corners
        push_cmd(F_PRINT,  0, 0, 0);
        push_cmd(F_GET,    1, 0, 0);
        push_cmd(F_DELETE, 1, 0, 0);
        push_cmd(F_INSERT, 0, 8'h11, 0);
        push_cmd(F_INSERT, 2, 8'h22, 0);
        // append, front and middle insert
        push_cmd(F_INSERT, 1, 8'h00, 0);
        push_cmd(F_INSERT, 2, 8'hff, 0);
        push_cmd(F_INSERT, 1, 8'ha5, 0);
        push_cmd(F_INSERT, 2, 8'h5a, 0);
        push_cmd(F_INSERT, 63, 8'h3c, 0);
        push_cmd(F_GET,    4, 0, 0);
        push_cmd(F_GET,    1, 0, 0);
        push_cmd(F_GET,    5, 0, 0);
        push_cmd(F_GET,    63, 8'hff, 0);
        push_cmd(F_PRINT,  0, 0, 0);
        push_cmd(F_DELETE, 2, 0, 0);
        push_cmd(F_DELETE, 3, 0, 0);
        push_cmd(F_DELETE, 1, 0, 0);
        push_cmd(F_DELETE, 0, 0, 0);
        push_cmd(F_DELETE, 63, 0, 0);
        push_cmd(F_PRINT,  0, 0, 0);

        n_rand = cmd_q.size();
        for (k = 0; k < 30; k++) begin
            rand_cmd(GROW, k == 0);
            n_rand++;
        end
        while (gen_len < CAPACITY) begin
            push_cmd(F_INSERT, $urandom_range(1, gen_len + 1), $urandom_range(0, 255), 0);
            n_rand++;
        end
        // full store: insert rejected as full, positions past the end, then a get of the last element
        push_cmd(F_INSERT, $urandom_range(1, CAPACITY + 1), $urandom_range(0, 255), 0);
        push_cmd(F_INSERT, CAPACITY + 2, $urandom_range(0, 255), 0);
        push_cmd(F_INSERT, 63, 8'hff, 0);
        push_cmd(F_DELETE, CAPACITY + 1, 0, 0);
        push_cmd(F_GET, CAPACITY, 0, 0);
        n_rand += 5;
        // long listings while the receiver holds off
        stall_at = cmd_q.size();
        for (k = 0; k < 4; k++) begin
            push_cmd(F_PRINT, $urandom_range(0, 63), $urandom_range(0, 255), 0);
            push_cmd(F_GET, $urandom_range(1, CAPACITY), $urandom_range(0, 255), 0);
            n_rand += 2;
        end
        phase = 0;
        while (n_rand < 180) begin
            mode = (phase % 3 == 0) ? SHRINK : (phase % 3 == 1) ? MIXED : GROW;
            for (k = 0; k < 25; k++) begin
                rand_cmd(mode, 0);
                n_rand++;
            end
            phase++;
        end
        n_total = cmd_q.size();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_q.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (reply_q.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("ran %0d beats: %0d insert, %0d delete, %0d get, %0d print",
                 n_taken, op_seen[F_INSERT], op_seen[F_DELETE], op_seen[F_GET],
                 op_seen[F_PRINT]);
        $display("compared %0d results, %0d full-store rejects, %0d mismatches",
                 n_checked, full_hits, bad_cnt);
        if (bad_cnt == 0)
            $display("positional_char_list verification clean");
        else
            $display("positional_char_list verification failed");
        $finish;
    end

endmodule
